/* hw/rtl/pcbc_pkg.sv */
// Package for the per-CPU size class block cache.
// Holds sizing constants, register and operation codes, and the store write port type.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package pcbc_pkg;

	localparam int NUM_CPUS    = 8;
	localparam int CLASS_COUNT = 16;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_BITS   = 48;

	localparam int CPU_W     = 3;
	localparam int CLASS_W   = 4;
	// A slot is {cpu, class}; this holds because CLASS_COUNT is 2**CLASS_W.
	localparam int SLOT_W    = CPU_W + CLASS_W;
	localparam int NUM_SLOTS = 1 << SLOT_W;
	localparam int IDX_W     = $clog2(STACK_DEPTH);
	localparam int CNT_W     = 7;
	localparam int STORE_AW  = SLOT_W + IDX_W;
	localparam int STORE_N   = 1 << STORE_AW;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

	localparam logic KIND_POP  = 1'b0;
	localparam logic KIND_PUSH = 1'b1;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

	typedef struct packed {
		logic                 en;
		logic [STORE_AW-1:0]  addr;
		logic [ADDR_BITS-1:0] data;
	} pcbc_wr_t;

endpackage

/* hw/rtl/pcbc_if.sv */
// Handshake interfaces for the block cache: request, response and configuration.
// Each carries valid, ready and the payload. Depends on pcbc_pkg.
`timescale 1ns / 1ps

interface pcbc_req_if
	import pcbc_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [CPU_W-1:0]     cpu_index;
	logic [CLASS_W-1:0]   size_class;
	logic [ADDR_BITS-1:0] push_address;

	modport source (output valid, kind, cpu_index, size_class, push_address, input ready);
	modport sink   (input valid, kind, cpu_index, size_class, push_address, output ready);
endinterface

interface pcbc_rsp_if
	import pcbc_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] pop_address;
	logic                 success;

	modport source (output valid, pop_address, success, input ready);
	modport sink   (input valid, pop_address, success, output ready);
endinterface

interface pcbc_cfg_if
	import pcbc_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pcbc_stack_ram.sv */
// Block address store: one entry per stack position of every CPU and class stack.
// Single write port, one registered read port. Depends on pcbc_pkg.
`timescale 1ns / 1ps

module pcbc_stack_ram
	import pcbc_pkg::*;
(
	input  logic                 clk,
	input  pcbc_wr_t             wr,
	input  logic [STORE_AW-1:0]  raddr,
	output logic [ADDR_BITS-1:0] rdata
);

	logic [ADDR_BITS-1:0] mem [STORE_N];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/per_cpu_class_block_cache_unit.sv */
// Per-CPU size class block cache: a bounded LIFO of freed block addresses per CPU and class.
// A push or a missing pop gives its result beat after the count memory read; a pop hit
// also waits for the registered address store read. One item is handled at a time: the
// next request is taken only once the result beat is loaded, so a response stall holds it.
// Reset: arst_n clears depth valid bits, sets enable to 0 and capacity_limit to 64.
// The address store is not cleared; a read entry is only used below its stack's depth.
`timescale 1ns / 1ps

module per_cpu_class_block_cache_unit
	import pcbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pcbc_cfg_if.sink   cfg,
	pcbc_req_if.sink   req,
	pcbc_rsp_if.source rsp
);

	// Sequencer states. IDLE takes a request and starts the count read. CNT sees the
	// depth, decides, and writes back a changed count. POP waits for the address store read.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CNT  = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
	logic             enable_q;
	logic [CNT_W-1:0] limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			limit_q  <= LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ENABLE: enable_q <= cfg.data[0];
				REG_LIMIT:  limit_q  <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Latched request payload.
	logic                 kind_q;
	logic [CPU_W-1:0]     cpu_q;
	logic [CLASS_W-1:0]   class_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [IDX_W-1:0]     pop_idx_q;

	logic req_fire;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	logic [SLOT_W-1:0] slot_q;
	assign slot_q = {cpu_q, class_q};

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q  <= req.kind;
			cpu_q   <= req.cpu_index;
			class_q <= req.size_class;
			addr_q  <= req.push_address;
		end
	end

	// Depth counters live in a memory with a registered read. A valid bit per slot stands
	// in for the reset value of zero, so no clearing pass is needed. The read address is
	// the incoming request in IDLE and the latched slot afterwards, so a stalled CNT state
	// keeps rereading the same, unchanged entry.
	logic [CNT_W-1:0]     cnt_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] cnt_vld_q;
	logic [CNT_W-1:0]     cnt_rd_q;
	logic                 cnt_hit_q;
	logic [SLOT_W-1:0]    cnt_raddr;
	logic                 cnt_we;
	logic [CNT_W-1:0]     cnt_wdata;

	assign cnt_raddr = (state_q == ST_IDLE) ? {req.cpu_index, req.size_class} : slot_q;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[slot_q] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			cnt_hit_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[slot_q] <= 1'b1;
			end
			cnt_hit_q <= cnt_vld_q[cnt_raddr];
		end
	end

	// Decision made in CNT. Accesses never overlap: the count write lands before the
	// next request can even start its read, so no forwarding path is required.
	logic [CNT_W-1:0] depth;
	logic [CNT_W-1:0] depth_dec;
	logic             in_range;
	logic             armed;
	logic             push_ok;
	logic             pop_ok;
	logic             out_free;

	assign depth     = cnt_hit_q ? cnt_rd_q : '0;
	assign depth_dec = depth - CNT_W'(1);
	assign in_range  = (32'(cpu_q) < NUM_CPUS) && (32'(class_q) < CLASS_COUNT);
	assign armed     = enable_q && in_range;
	assign push_ok   = armed && (kind_q == KIND_PUSH) && (depth < limit_q)
	                   && (depth < CNT_W'(STACK_DEPTH));
	assign pop_ok    = armed && (kind_q == KIND_POP) && (depth != '0);
	assign out_free  = !rsp.valid || rsp.ready;

	// A push commits only together with its result beat. A pop hit commits at once and
	// moves on to the store read; its result waits in POP if the response side stalls.
	assign cnt_we    = (state_q == ST_CNT) && ((push_ok && out_free) || pop_ok);
	assign cnt_wdata = push_ok ? (depth + CNT_W'(1)) : depth_dec;

	pcbc_wr_t             store_wr;
	logic [IDX_W-1:0]     store_ridx;
	logic [ADDR_BITS-1:0] store_rdata;

	assign store_wr.en   = (state_q == ST_CNT) && push_ok && out_free;
	assign store_wr.addr = {slot_q, depth[IDX_W-1:0]};
	assign store_wr.data = addr_q;
	assign store_ridx    = (state_q == ST_CNT) ? depth_dec[IDX_W-1:0] : pop_idx_q;

	pcbc_stack_ram u_store (
		.clk   (clk),
		.wr    (store_wr),
		.raddr ({slot_q, store_ridx}),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CNT) begin
			pop_idx_q <= depth_dec[IDX_W-1:0];
		end
	end

	// Response register: a beat waits here while the sequencer returns to IDLE and
	// takes the next request.
	logic                 rsp_vld_q;
	logic [ADDR_BITS-1:0] rsp_addr_q;
	logic                 rsp_ok_q;
	logic                 rsp_load;
	logic [ADDR_BITS-1:0] rsp_addr_d;
	logic                 rsp_ok_d;

	always_comb begin
		state_d    = state_q;
		rsp_load   = 1'b0;
		rsp_addr_d = '0;
		rsp_ok_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				if (pop_ok) begin
					state_d = ST_POP;
				end else if (out_free) begin
					rsp_load = 1'b1;
					rsp_ok_d = push_ok;
					state_d  = ST_IDLE;
				end
			end
			ST_POP: begin
				if (out_free) begin
					rsp_load   = 1'b1;
					rsp_addr_d = store_rdata;
					rsp_ok_d   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_addr_q <= rsp_addr_d;
			rsp_ok_q   <= rsp_ok_d;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.pop_address = rsp_addr_q;
	assign rsp.success     = rsp_ok_q;

endmodule

/* bench/tb_per_cpu_class_block_cache_unit.sv */
// Self-checking testbench for per_cpu_class_block_cache_unit: directed cases, then random traffic.
// Predicts each response beat from its own copy of the stacks and registers and compares in order.
// Depends on pcbc_pkg, the pcbc interfaces and the cache unit itself.
`timescale 1ns / 1ps

module tb_per_cpu_class_block_cache_unit;
	import pcbc_pkg::*;

	// Register indexes beyond the defined ones; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	// Generous bound on the whole run, far above the slowest legal schedule.
	localparam int CYCLE_LIMIT = 400000;
	// Cycles to let pass after the last response beat, so that the block is idle again.
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [ADDR_BITS-1:0] pop_address;
		logic                 success;
	} cache_rsp_t;

	logic clk;
	logic arst_n;

	pcbc_cfg_if cfg_if ();
	pcbc_req_if req_if ();
	pcbc_rsp_if rsp_if ();

	per_cpu_class_block_cache_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the cache: one address stack and one depth per {cpu, class} slot.
	logic [ADDR_BITS-1:0] shadow_store [NUM_SLOTS][STACK_DEPTH];
	int                   shadow_depth [NUM_SLOTS];
	logic                 shadow_enable;
	logic [CNT_W-1:0]     shadow_limit;

	// Response beats still owed by the block, oldest first.
	cache_rsp_t expected_rsp_q [$];

	int mismatch_count;
	int cycle_count;

	// Idle percentages for the sender and the receiver, and a request for a long receiver stall.
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_stall_req;
	int rx_stall_left;

	always #2 clk = ~clk;

	// Works out the response that one request beat produces and updates the shadow cache.
	function automatic cache_rsp_t predict_cache(input logic kind, input logic [CPU_W-1:0] cpu,
			input logic [CLASS_W-1:0] cls, input logic [ADDR_BITS-1:0] addr);
		cache_rsp_t r;
		int slot;
		int d;
		r = '0;
		slot = cpu * CLASS_COUNT + cls;
		if (shadow_enable && cpu < NUM_CPUS && cls < CLASS_COUNT) begin
			d = shadow_depth[slot];
			if (kind == KIND_PUSH) begin
				if (d < shadow_limit && d < STACK_DEPTH) begin
					shadow_store[slot][d] = addr;
					shadow_depth[slot] = d + 1;
					r.success = 1'b1;
				end
			end else if (d > 0) begin
				d = d - 1;
				r.pop_address = shadow_store[slot][d];
				shadow_depth[slot] = d;
				r.success = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [ADDR_BITS-1:0] rand_address();
		int pick;
		pick = $urandom_range(15);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return ADDR_BITS'({$urandom, $urandom});
	endfunction

	// Offers one request beat, idling first at the sender's rate, and records the expected
	// response once the beat is accepted. Called and returns in the time step of a rising edge.
	task automatic send_req(input logic kind, input logic [CPU_W-1:0] cpu,
			input logic [CLASS_W-1:0] cls, input logic [ADDR_BITS-1:0] addr);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.kind         <= kind;
		req_if.cpu_index    <= cpu;
		req_if.size_class   <= cls;
		req_if.push_address <= addr;
		do
			@(posedge clk);
		while (!(req_if.valid && req_if.ready));
		expected_rsp_q.push_back(predict_cache(kind, cpu, cls, addr));
	endtask

	// Stops offering requests until every owed response beat has come, then lets the
	// block settle so that it is idle for a register write.
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsp_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one configuration register. Only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		case (idx)
			REG_ENABLE: shadow_enable = value[0];
			REG_LIMIT:  shadow_limit = value;
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Out of reset the cache is disarmed: the pop misses and the push is refused.
	task automatic test_reset_state();
		send_req(KIND_POP, 3'd0, 4'd0, '0);
		send_req(KIND_PUSH, 3'd0, 4'd0, 48'h0000_1234_5678);
		wait_for_results();
		write_reg(REG_ENABLE, 7'd1);
	endtask

	// Field extremes, a zero address stored and returned, alternating bit patterns, and a
	// pop on an empty stack.
	task automatic test_field_extremes();
		send_req(KIND_PUSH, 3'd7, 4'd15, '1);
		send_req(KIND_PUSH, 3'd0, 4'd0, '0);
		send_req(KIND_PUSH, 3'd0, 4'd0, 48'hAAAA_AAAA_AAAA);
		send_req(KIND_PUSH, 3'd5, 4'd10, 48'h5555_5555_5555);
		send_req(KIND_POP, 3'd7, 4'd15, '0);
		send_req(KIND_POP, 3'd0, 4'd0, '1);
		send_req(KIND_POP, 3'd0, 4'd0, '0);
		send_req(KIND_POP, 3'd0, 4'd0, '0);
		send_req(KIND_POP, 3'd5, 4'd10, '0);
		send_req(KIND_POP, 3'd7, 4'd15, '0);
		wait_for_results();
	endtask

	// Writes to undefined register indexes must change nothing, and only bit 0 of the
	// enable data counts.
	task automatic test_register_writes();
		write_reg(REG_SPARE_LO, 7'd0);
		write_reg(REG_SPARE_HI, 7'd1);
		send_req(KIND_PUSH, 3'd4, 4'd2, rand_address());
		send_req(KIND_PUSH, 3'd4, 4'd2, rand_address());
		send_req(KIND_POP, 3'd4, 4'd2, '0);
		send_req(KIND_POP, 3'd4, 4'd2, '0);
		wait_for_results();
		write_reg(REG_ENABLE, 7'h7E);
		send_req(KIND_PUSH, 3'd4, 4'd2, rand_address());
		wait_for_results();
		write_reg(REG_ENABLE, 7'h7F);
	endtask

	// A disabled cache keeps its contents; they come back once it is armed again.
	task automatic test_disabled_cache();
		for (int i = 0; i < 3; i++)
			send_req(KIND_PUSH, 3'd2, 4'd3, rand_address());
		wait_for_results();
		write_reg(REG_ENABLE, 7'd0);
		send_req(KIND_POP, 3'd2, 4'd3, '0);
		send_req(KIND_PUSH, 3'd2, 4'd3, rand_address());
		wait_for_results();
		write_reg(REG_ENABLE, 7'd1);
		for (int i = 0; i < 4; i++)
			send_req(KIND_POP, 3'd2, 4'd3, '0);
		wait_for_results();
	endtask

	// Lowering the limit under the current depth refuses pushes while pops still drain.
	task automatic test_limit_lowered();
		for (int i = 0; i < 4; i++)
			send_req(KIND_PUSH, 3'd6, 4'd9, rand_address());
		wait_for_results();
		write_reg(REG_LIMIT, 7'd2);
		send_req(KIND_PUSH, 3'd6, 4'd9, rand_address());
		for (int i = 0; i < 5; i++)
			send_req(KIND_POP, 3'd6, 4'd9, '0);
		wait_for_results();
		write_reg(REG_LIMIT, LIMIT_RESET);
	endtask

	// A limit above the stack size still stops at the stack size; a limit of zero refuses every push.
	task automatic test_capacity_above_depth();
		write_reg(REG_LIMIT, 7'd127);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_req(KIND_PUSH, 3'd1, 4'd12, rand_address());
		wait_for_results();
		write_reg(REG_LIMIT, 7'd0);
		send_req(KIND_PUSH, 3'd3, 4'd3, rand_address());
		send_req(KIND_PUSH, 3'd1, 4'd12, rand_address());
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_req(KIND_POP, 3'd1, 4'd12, '0);
		wait_for_results();
		write_reg(REG_LIMIT, LIMIT_RESET);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering beats, so
	// the block fills up and must stall its request side.
	task automatic test_backpressure();
		logic kind;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_stall_req = 300;
		for (int i = 0; i < 40; i++) begin
			kind = ($urandom_range(1) == 1) ? KIND_PUSH : KIND_POP;
			send_req(kind, 3'd5, CLASS_W'($urandom_range(1)), rand_address());
		end
		wait_for_results();
	endtask

	// Random traffic, mostly on two hot slots so that stacks grow deep, with the push rate
	// swinging between filling and draining.
	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
		int hot_a;
		int hot_b;
		int slot;
		int pick;
		int push_pct;
		logic kind;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		hot_a = $urandom_range(NUM_SLOTS - 1);
		hot_b = $urandom_range(NUM_SLOTS - 1);
		push_pct = 30;
		for (int i = 0; i < n_items; i++) begin
			if (i % 60 == 0)
				push_pct = (push_pct == 70) ? 30 : 70;
			pick = $urandom_range(99);
			slot = (pick < 45) ? hot_a : (pick < 70) ? hot_b : $urandom_range(NUM_SLOTS - 1);
			kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
			send_req(kind, slot[SLOT_W-1:CLASS_W], slot[CLASS_W-1:0], rand_address());
		end
		wait_for_results();
	endtask

	// Receiver: random idling, plus a long stall when a test asks for one. The stall is
	// counted here so that it runs independently of the sender.
	always @(posedge clk) begin
		if (rx_stall_req > 0) begin
			rx_stall_left = rx_stall_req;
			rx_stall_req = 0;
		end
		if (rx_stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			rx_stall_left = rx_stall_left - 1;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Checks every accepted response beat against the oldest expectation, field by field.
	always @(posedge clk) begin
		cache_rsp_t exp_rsp;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: response beat with none expected: pop_address %h success %b",
					$time, rsp_if.pop_address, rsp_if.success);
				mismatch_count++;
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				if (rsp_if.pop_address !== exp_rsp.pop_address) begin
					$display("%0t: pop_address expected %h actual %h",
						$time, exp_rsp.pop_address, rsp_if.pop_address);
					mismatch_count++;
				end
				if (rsp_if.success !== exp_rsp.success) begin
					$display("%0t: success expected %b actual %b",
						$time, exp_rsp.success, rsp_if.success);
					mismatch_count++;
				end
			end
		end
	end

	// A hung handshake anywhere ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_POP;
		req_if.cpu_index = '0;
		req_if.size_class = '0;
		req_if.push_address = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ENABLE;
		cfg_if.data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_stall_req = 0;
		rx_stall_left = 0;
		shadow_enable = 1'b0;
		shadow_limit = LIMIT_RESET;
		for (int s = 0; s < NUM_SLOTS; s++)
			shadow_depth[s] = 0;

		// Reset is released on a rising edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_register_writes();
		test_disabled_cache();
		test_limit_lowered();
		test_capacity_above_depth();
		test_backpressure();

		// Three random phases under different limits: a tight one that refuses often,
		// one above the stack size, and the reset value.
		write_reg(REG_LIMIT, 7'd8);
		test_random_traffic(364, 20, 48);
		write_reg(REG_LIMIT, 7'd127);
		test_random_traffic(364, 48, 20);
		write_reg(REG_LIMIT, LIMIT_RESET);
		test_random_traffic(364, 0, 0);

		wait_for_results();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
